/* sv/sorted_table_linear_interp_assert.svh */
// Assertion macros for the sorted table interpolator.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef SORTED_TABLE_LINEAR_INTERP_ASSERT_SVH
`define SORTED_TABLE_LINEAR_INTERP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define STLI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define STLI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/stli_pkg.sv */
// Shared types and constants for the sorted table interpolator.
// No dependencies; used by stli_mul_div and sorted_table_linear_interp.
`timescale 1ns / 1ps

package stli_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int DATA_W          = 32;
    localparam int PROD_W          = 2 * DATA_W;
    localparam int MAG_W           = 35;
    localparam int STEP_W          = $clog2(PROD_W);

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_INTERP = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_DUP    = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_ABSENT = 3'd3;
    localparam logic [2:0] ST_FEW    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DISPATCH,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_FETCH_LO,
        S_FETCH_HI,
        S_FETCH_END,
        S_DIFF,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SUM
    } stli_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_STEP
    } div_state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] mult_a;
        logic [DATA_W-1:0] mult_b;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quot;
    } div_rsp_t;

endpackage

/* sv/sorted_table_linear_interp.sv */
// Sorted breakpoint table with piecewise-linear interpolation, top level.
// Depends on stli_pkg, stli_mul_div and sorted_table_linear_interp_assert.svh.
//
// Usage:
//   Command channel: drive mode, point_key and point_value with start high;
//   the transaction is taken at a rising edge where start is high and busy is
//   low. busy stays high until the transaction is finished.
//   Result channel: done is high for exactly one cycle with result_value and
//   status valid. The receiver cannot stall; the result must be taken then.
// Operation:
//   The table is walked linearly through one read port, a read and a compare
//   state per key. Insert and a found delete then shift the entries after the
//   search position; a rejected insert or an absent key ends after the search.
//   Interpolate: the multiply/divide unit takes a multiply step and 64
//   one-bit division steps. Exact key hits skip it.
//   Unused mode and interpolation on fewer than two points end from idle.
//   A new command may be issued in the cycle where done is high.
// Reset: the table is emptied (point count cleared); stored entries are not
//   swept and are never read before being written.
`timescale 1ns / 1ps

module sorted_table_linear_interp
    import stli_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               mode,
    input  logic signed [DATA_W-1:0] point_key,
    input  logic signed [DATA_W-1:0] point_value,
    output logic                     done,
    output logic signed [DATA_W-1:0] result_value,
    output logic [2:0]               status
);

    `include "sorted_table_linear_interp_assert.svh"

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = MAG_W + 1;

    stli_state_t state_reg, state_next;

    logic [1:0]               mode_reg, mode_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [CW-1:0]            pos_reg, pos_next;
    logic                     match_reg, match_next;
    logic signed [DATA_W-1:0] x0_reg, x0_next;
    logic signed [DATA_W-1:0] y0_reg, y0_next;
    logic signed [DATA_W-1:0] x1_reg, x1_next;
    logic signed [DATA_W-1:0] y1_reg, y1_next;
    logic [DATA_W-1:0]        mag_a_reg, mag_a_next;
    logic [DATA_W-1:0]        mag_b_reg, mag_b_next;
    logic [DATA_W-1:0]        dx_reg, dx_next;
    logic                     neg_reg, neg_next;
    logic                     done_reg, done_next;
    logic signed [DATA_W-1:0] result_reg, result_next;
    logic [2:0]               status_reg, status_next;

    // table storage
    logic signed [DATA_W-1:0] key_mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] val_mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] rd_key_reg;
    logic signed [DATA_W-1:0] rd_val_reg;
    logic [AW-1:0]            raddr;
    logic [AW-1:0]            waddr;
    logic                     we;
    logic signed [DATA_W-1:0] wkey;
    logic signed [DATA_W-1:0] wval;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic                key_less;
    logic                key_equal;
    logic [CW-1:0]       idx_dec;
    logic [CW-1:0]       idx_inc;
    logic [CW-1:0]       shift_src;
    logic [CW-1:0]       pos_inc;
    logic [CW-1:0]       count_dec;
    logic                table_full;
    logic                few_points;
    logic [CW-1:0]       upper_idx;
    logic [DATA_W:0]     dy_ext;
    logic [DATA_W:0]     dq_ext;
    logic [DATA_W:0]     dx_ext;
    logic [DATA_W:0]     dy_abs;
    logic [DATA_W:0]     dq_abs;
    logic [SW-1:0]       y0_wide;
    logic [SW-1:0]       mag_wide;
    logic [SW-1:0]       sum_wide;
    logic signed [DATA_W-1:0] sum_sat;

    assign key_less   = (rd_key_reg < key_reg);
    assign key_equal  = (rd_key_reg == key_reg);
    assign idx_dec    = idx_reg - 1'b1;
    assign idx_inc    = idx_reg + 1'b1;
    assign shift_src  = (mode_reg == MODE_INSERT) ? idx_dec : idx_inc;
    assign pos_inc    = pos_reg + 1'b1;
    assign count_dec  = count_reg - 1'b1;
    assign table_full = (count_reg == CW'(TABLE_DEPTH));
    assign few_points = (count_reg < CW'(2));

    // upper neighbor index, clamped so that both neighbors exist
    always_comb
    begin
        if (pos_reg == '0)
        begin
            upper_idx = CW'(1);
        end
        else if (pos_reg >= count_reg)
        begin
            upper_idx = count_dec;
        end
        else
        begin
            upper_idx = pos_reg;
        end
    end

    assign dy_ext = {y1_reg[DATA_W-1], y1_reg} - {y0_reg[DATA_W-1], y0_reg};
    assign dq_ext = {key_reg[DATA_W-1], key_reg} - {x0_reg[DATA_W-1], x0_reg};
    assign dx_ext = {x1_reg[DATA_W-1], x1_reg} - {x0_reg[DATA_W-1], x0_reg};
    assign dy_abs = dy_ext[DATA_W] ? (~dy_ext + 1'b1) : dy_ext;
    assign dq_abs = dq_ext[DATA_W] ? (~dq_ext + 1'b1) : dq_ext;

    assign y0_wide  = {{(SW-DATA_W){y0_reg[DATA_W-1]}}, y0_reg};
    assign mag_wide = {1'b0, div_rsp.quot};
    assign sum_wide = neg_reg ? (y0_wide - mag_wide) : (y0_wide + mag_wide);

    // saturate to the signed 32-bit range
    always_comb
    begin
        if ((&sum_wide[SW-1:DATA_W-1]) || !(|sum_wide[SW-1:DATA_W-1]))
        begin
            sum_sat = sum_wide[DATA_W-1:0];
        end
        else if (sum_wide[SW-1])
        begin
            sum_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            sum_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (mode) inside
                        MODE_INSERT, MODE_DELETE:
                        begin
                            state_next = S_SCAN_RD;
                        end
                        MODE_INTERP:
                        begin
                            state_next = few_points ? S_IDLE : S_SCAN_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                state_next = (idx_reg == count_reg) ? S_DISPATCH : S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                state_next = key_less ? S_SCAN_RD : S_DISPATCH;
            end
            S_DISPATCH:
            begin
                unique case (mode_reg) inside
                    MODE_INSERT:
                    begin
                        if (match_reg || table_full)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (pos_reg == count_reg)
                        begin
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            state_next = S_SHIFT_RD;
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (!match_reg || (pos_inc == count_reg))
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SHIFT_RD;
                        end
                    end
                    default:
                    begin
                        state_next = match_reg ? S_IDLE : S_FETCH_LO;
                    end
                endcase
            end
            S_SHIFT_RD:
            begin
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                if (mode_reg == MODE_INSERT)
                begin
                    state_next = (shift_src == pos_reg) ? S_PLACE : S_SHIFT_RD;
                end
                else
                begin
                    state_next = (CW'(shift_src + 1'b1) == count_reg) ? S_IDLE : S_SHIFT_RD;
                end
            end
            S_PLACE:
            begin
                state_next = S_IDLE;
            end
            S_FETCH_LO:
            begin
                state_next = S_FETCH_HI;
            end
            S_FETCH_HI:
            begin
                state_next = S_FETCH_END;
            end
            S_FETCH_END:
            begin
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                state_next = div_rsp.done ? S_SUM : S_DIV_WAIT;
            end
            S_SUM:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        mode_next   = mode_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        match_next  = match_reg;
        x0_next     = x0_reg;
        y0_next     = y0_reg;
        x1_next     = x1_reg;
        y1_next     = y1_reg;
        mag_a_next  = mag_a_reg;
        mag_b_next  = mag_b_reg;
        dx_next     = dx_reg;
        neg_next    = neg_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        status_next = status_reg;
        raddr       = idx_reg[AW-1:0];
        waddr       = idx_reg[AW-1:0];
        we          = 1'b0;
        wkey        = rd_key_reg;
        wval        = rd_val_reg;
        div_req.start   = 1'b0;
        div_req.mult_a  = mag_a_reg;
        div_req.mult_b  = mag_b_reg;
        div_req.divisor = dx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    key_next   = point_key;
                    val_next   = point_value;
                    idx_next   = '0;
                    match_next = 1'b0;
                    if (mode == MODE_NONE)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                        status_next = ST_OK;
                    end
                    else if ((mode == MODE_INTERP) && few_points)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                        status_next = ST_FEW;
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    pos_next   = idx_reg;
                    match_next = 1'b0;
                end
            end
            S_SCAN_CMP:
            begin
                // raddr stays on idx, so the entry is still on the read port next cycle
                if (key_less)
                begin
                    idx_next = idx_inc;
                end
                else
                begin
                    pos_next   = idx_reg;
                    match_next = key_equal;
                end
            end
            S_DISPATCH:
            begin
                unique case (mode_reg) inside
                    MODE_INSERT:
                    begin
                        if (match_reg)
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                            status_next = ST_DUP;
                        end
                        else if (table_full)
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            idx_next = count_reg;
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (!match_reg)
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                            status_next = ST_ABSENT;
                        end
                        else if (pos_inc == count_reg)
                        begin
                            count_next  = count_dec;
                            done_next   = 1'b1;
                            result_next = '0;
                            status_next = ST_OK;
                        end
                        else
                        begin
                            idx_next = pos_reg;
                        end
                    end
                    default:
                    begin
                        if (match_reg)
                        begin
                            done_next   = 1'b1;
                            result_next = rd_val_reg;
                            status_next = ST_OK;
                        end
                        else
                        begin
                            idx_next = upper_idx;
                        end
                    end
                endcase
            end
            S_SHIFT_RD:
            begin
                raddr = shift_src[AW-1:0];
            end
            S_SHIFT_WR:
            begin
                we       = 1'b1;
                waddr    = idx_reg[AW-1:0];
                idx_next = shift_src;
                if ((mode_reg == MODE_DELETE) && (CW'(shift_src + 1'b1) == count_reg))
                begin
                    count_next  = count_dec;
                    done_next   = 1'b1;
                    result_next = '0;
                    status_next = ST_OK;
                end
            end
            S_PLACE:
            begin
                we          = 1'b1;
                waddr       = pos_reg[AW-1:0];
                wkey        = key_reg;
                wval        = val_reg;
                count_next  = count_reg + 1'b1;
                done_next   = 1'b1;
                result_next = '0;
                status_next = ST_OK;
            end
            S_FETCH_LO:
            begin
                raddr = idx_dec[AW-1:0];
            end
            S_FETCH_HI:
            begin
                x0_next = rd_key_reg;
                y0_next = rd_val_reg;
            end
            S_FETCH_END:
            begin
                x1_next = rd_key_reg;
                y1_next = rd_val_reg;
            end
            S_DIFF:
            begin
                mag_a_next = dy_abs[DATA_W-1:0];
                mag_b_next = dq_abs[DATA_W-1:0];
                dx_next    = dx_ext[DATA_W-1:0];
                neg_next   = dy_ext[DATA_W] ^ dq_ext[DATA_W];
            end
            S_DIV_GO:
            begin
                div_req.start = 1'b1;
            end
            S_DIV_WAIT:
            begin
                done_next = 1'b0;
            end
            S_SUM:
            begin
                done_next   = 1'b1;
                result_next = sum_sat;
                status_next = ST_OK;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr] <= wkey;
            val_mem[waddr] <= wval;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key_reg <= key_mem[raddr];
        rd_val_reg <= val_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            pos_reg    <= '0;
            match_reg  <= 1'b0;
            mode_reg   <= MODE_INSERT;
            done_reg   <= 1'b0;
            result_reg <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            pos_reg    <= pos_next;
            match_reg  <= match_next;
            mode_reg   <= mode_next;
            done_reg   <= done_next;
            result_reg <= result_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        val_reg   <= val_next;
        x0_reg    <= x0_next;
        y0_reg    <= y0_next;
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        mag_a_reg <= mag_a_next;
        mag_b_reg <= mag_b_next;
        dx_reg    <= dx_next;
        neg_reg   <= neg_next;
    end

    stli_mul_div u_mul_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign result_value = result_reg;
    assign status       = status_reg;

    `STLI_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(TABLE_DEPTH))
    `STLI_ASSERT_NXT(a_place_grows, state_reg == S_PLACE, count_reg == CW'($past(count_reg) + 1'b1))
    `STLI_ASSERT_IMP(a_div_nonzero, state_reg == S_DIV_GO, div_req.divisor != '0)
    `STLI_ASSERT_IMP(a_error_zero, done_reg && (status_reg != ST_OK), result_reg == '0)

endmodule

/* sv/stli_mul_div.sv */
// Multiply then divide unit: floor(a*b/d), clamped to 2^34.
// A multiply step, then 64 restoring division steps. Depends on stli_pkg.
`timescale 1ns / 1ps

module stli_mul_div
    import stli_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    div_state_t          state_reg, state_next;
    logic [DATA_W-1:0]   a_reg, a_next;
    logic [DATA_W-1:0]   b_reg, b_next;
    logic [DATA_W-1:0]   d_reg, d_next;
    logic [PROD_W-1:0]   work_reg, work_next;
    logic [DATA_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                done_reg, done_next;
    logic [MAG_W-1:0]    quot_reg, quot_next;

    logic [DATA_W:0]     trial;
    logic [DATA_W:0]     trial_sub;
    logic                trial_ge;
    logic [PROD_W-1:0]   work_shift;

    assign trial      = {rem_reg, work_reg[PROD_W-1]};
    assign trial_sub  = trial - {1'b0, d_reg};
    assign trial_ge   = (trial >= {1'b0, d_reg});
    assign work_shift = {work_reg[PROD_W-2:0], trial_ge};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (req.start)
                begin
                    state_next = DIV_MUL;
                end
            end
            DIV_MUL:
            begin
                state_next = DIV_STEP;
            end
            DIV_STEP:
            begin
                if (step_reg == STEP_W'(PROD_W - 1))
                begin
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        d_next    = d_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (req.start)
                begin
                    a_next = req.mult_a;
                    b_next = req.mult_b;
                    d_next = req.divisor;
                end
            end
            DIV_MUL:
            begin
                work_next = a_reg * b_reg;
                rem_next  = '0;
                step_next = '0;
            end
            DIV_STEP:
            begin
                rem_next  = trial_ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
                work_next = work_shift;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(PROD_W - 1))
                begin
                    done_next = 1'b1;
                    // clamp any quotient of 2^34 or more
                    if (|work_shift[PROD_W-1:MAG_W-1])
                    begin
                        quot_next = {1'b1, {(MAG_W-1){1'b0}}};
                    end
                    else
                    begin
                        quot_next = work_shift[MAG_W-1:0];
                    end
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        d_reg    <= d_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule
